/* rtl/ipv4rx_pkg.sv */
package ipv4rx_pkg;

  localparam int WordWidth = 16;
  localparam int AddrWidth = 32;
  localparam int CountWidth = 6;
  localparam int HeaderWordsWidth = 5;

  localparam logic [CountWidth-1:0] MinHeaderWords = 6'd10;
  localparam logic [CountWidth-1:0] ChecksumWord = 6'd5;

  typedef enum logic [CountWidth-1:0] {
    WordVersion    = 6'd0,
    WordTotalLen   = 6'd1,
    WordProtocol   = 6'd4,
    WordChecksum   = 6'd5,
    WordSrcHigh    = 6'd6,
    WordSrcLow     = 6'd7,
    WordDstHigh    = 6'd8,
    WordDstLow     = 6'd9
  } word_index_t;

  localparam logic [1:0] VerdictAccept = 2'd0;
  localparam logic [1:0] VerdictNotOurs = 2'd1;
  localparam logic [1:0] VerdictBadSum = 2'd2;
  localparam logic [1:0] VerdictTooLong = 2'd3;

  localparam logic [1:0] ClassIcmp = 2'd0;
  localparam logic [1:0] ClassTcp = 2'd1;
  localparam logic [1:0] ClassUdp = 2'd2;
  localparam logic [1:0] ClassOther = 2'd3;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  function automatic logic [1:0] class_of(input logic [7:0] proto);
    logic [1:0] c;
    case (proto)
      ProtoIcmp: c = ClassIcmp;
      ProtoTcp:  c = ClassTcp;
      ProtoUdp:  c = ClassUdp;
      default:   c = ClassOther;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ipv4rx_if.sv */
interface ipv4rx_in_if;
  logic                             valid;
  logic                             ready;
  logic [ipv4rx_pkg::WordWidth-1:0] header_word;
  logic [ipv4rx_pkg::WordWidth-1:0] frame_size;

  modport source(output valid, output header_word, output frame_size, input ready);
  modport sink(input valid, input header_word, input frame_size, output ready);
endinterface

interface ipv4rx_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       verdict;
  logic [1:0]                       protocol_class;
  logic [ipv4rx_pkg::WordWidth-1:0] payload_length;
  logic [ipv4rx_pkg::AddrWidth-1:0] source_address;

  modport source(output valid, output verdict, output protocol_class,
                 output payload_length, output source_address, input ready);
  modport sink(input valid, input verdict, input protocol_class,
               input payload_length, input source_address, output ready);
endinterface

interface ipv4rx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ipv4rx_pkg::AddrWidth-1:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/ipv4_receive_header_check.sv */
// A header's last word is accepted into the input register and then loads the
// result register, from which the result can be taken.
// Throughput: one header word per cycle; a result is held until taken, and only
// a last word waits behind a stalled result.
// Reset (rst, synchronous, active high) clears the word count, the pipeline
// valids and own_address.
module ipv4_receive_header_check (
  input  logic           clk,
  input  logic           rst,
  ipv4rx_cfg_if.sink     cfg,
  ipv4rx_in_if.sink      hdr,
  ipv4rx_out_if.source   res
);
  import ipv4rx_pkg::*;

  logic [AddrWidth-1:0]        own_address;

  // Input register.
  logic                        s1_valid;
  logic [WordWidth-1:0]        s1_word;
  logic [WordWidth-1:0]        s1_frame;

  // Header state.
  logic [CountWidth-1:0]       word_count;
  logic [HeaderWordsWidth-1:0] header_words;
  logic [WordWidth-1:0]        running_sum;
  logic [WordWidth-1:0]        stored_checksum;
  logic [WordWidth-1:0]        ip_length;
  logic [WordWidth-1:0]        frame_bytes;
  logic [7:0]                  protocol_number;
  logic [AddrWidth-1:0]        src_ip;
  logic [AddrWidth-1:0]        dst_ip;

  logic [CountWidth-1:0]       word_count_next;
  logic [HeaderWordsWidth-1:0] header_words_next;
  logic [WordWidth-1:0]        running_sum_next;
  logic [WordWidth-1:0]        stored_checksum_next;
  logic [WordWidth-1:0]        ip_length_next;
  logic [WordWidth-1:0]        frame_bytes_next;
  logic [7:0]                  protocol_number_next;
  logic [AddrWidth-1:0]        src_ip_next;
  logic [AddrWidth-1:0]        dst_ip_next;

  logic [WordWidth-1:0]        sum_base;
  logic [WordWidth-1:0]        addend;
  logic [WordWidth:0]          sum_wide;
  logic [WordWidth-1:0]        sum_folded;
  logic [CountWidth-1:0]       hw_ext;
  logic [CountWidth-1:0]       last_index;
  logic                        is_last;
  logic                        s1_advance;
  logic [1:0]                  verdict_next;

  assign cfg.ready = 1'b1;

  // Only a last word needs the result register; all other words pass freely.
  assign s1_advance = s1_valid && (!is_last || !res.valid || res.ready);
  assign hdr.ready  = !s1_valid || s1_advance;

  always_comb begin
    header_words_next    = header_words;
    frame_bytes_next     = frame_bytes;
    sum_base             = running_sum;
    stored_checksum_next = stored_checksum;
    ip_length_next       = ip_length;
    protocol_number_next = protocol_number;
    src_ip_next          = src_ip;
    dst_ip_next          = dst_ip;

    if (word_count == WordVersion) begin
      header_words_next = {s1_word[11:8], 1'b0};
      frame_bytes_next  = s1_frame;
      sum_base          = '0;
    end

    case (word_count)
      WordTotalLen: ip_length_next = s1_word;
      WordProtocol: protocol_number_next = s1_word[7:0];
      WordChecksum: stored_checksum_next = s1_word;
      WordSrcHigh:  src_ip_next[31:16] = s1_word;
      WordSrcLow:   src_ip_next[15:0] = s1_word;
      WordDstHigh:  dst_ip_next[31:16] = s1_word;
      WordDstLow:   dst_ip_next[15:0] = s1_word;
      default: ;
    endcase

    // Ones-complement add with end-around carry; the checksum field counts as zero.
    addend     = (word_count == ChecksumWord) ? '0 : s1_word;
    sum_wide   = {1'b0, sum_base} + {1'b0, addend};
    sum_folded = sum_wide[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, sum_wide[WordWidth]};

    hw_ext           = {1'b0, header_words_next};
    running_sum_next = (word_count < hw_ext) ? sum_folded : sum_base;

    last_index      = (hw_ext > MinHeaderWords) ? hw_ext - 6'd1 : MinHeaderWords - 6'd1;
    is_last         = (word_count >= last_index);
    word_count_next = is_last ? '0 : word_count + 6'd1;

    if (dst_ip_next != own_address) begin
      verdict_next = VerdictNotOurs;
    end else if (~running_sum_next != stored_checksum_next) begin
      verdict_next = VerdictBadSum;
    end else if (ip_length_next > frame_bytes_next) begin
      verdict_next = VerdictTooLong;
    end else begin
      verdict_next = VerdictAccept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
      s1_valid    <= 1'b0;
      word_count  <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        own_address <= cfg.data;
      end
      if (hdr.valid && hdr.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        word_count <= word_count_next;
      end
      if (s1_advance && is_last) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      s1_word  <= hdr.header_word;
      s1_frame <= hdr.frame_size;
    end
    if (s1_advance) begin
      header_words    <= header_words_next;
      running_sum     <= running_sum_next;
      stored_checksum <= stored_checksum_next;
      ip_length       <= ip_length_next;
      frame_bytes     <= frame_bytes_next;
      protocol_number <= protocol_number_next;
      src_ip          <= src_ip_next;
      dst_ip          <= dst_ip_next;
    end
    if (s1_advance && is_last) begin
      res.verdict        <= verdict_next;
      res.protocol_class <= class_of(protocol_number_next);
      res.payload_length <= ip_length_next - {10'd0, hw_ext[4:0], 1'b0};
      res.source_address <= src_ip_next;
    end
  end

endmodule

/* rtl/ipv4rx_checker.sv */
module ipv4rx_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             hdr_valid,
  input logic                             hdr_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [1:0]                       res_verdict,
  input logic [1:0]                       res_protocol_class,
  input logic [ipv4rx_pkg::WordWidth-1:0] res_payload_length,
  input logic [ipv4rx_pkg::AddrWidth-1:0] res_source_address
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_verdict) && $stable(res_protocol_class)
      && $stable(res_payload_length) && $stable(res_source_address))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // With the result register empty, the transaction that ends a header passes
  // through the input register and then through the result register before a
  // result shows up.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(hdr_valid && hdr_ready, 2))
    else $error("result without a preceding header transaction");

endmodule

bind ipv4_receive_header_check ipv4rx_checker u_ipv4rx_checker (
  .clk                (clk),
  .rst                (rst),
  .hdr_valid          (hdr.valid),
  .hdr_ready          (hdr.ready),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_verdict        (res.verdict),
  .res_protocol_class (res.protocol_class),
  .res_payload_length (res.payload_length),
  .res_source_address (res.source_address)
);
